// ===== sv/olar_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered list package
// Shared sizes, codes, payload types and the control link between the
// list controller and the list datapath.
// ----------------------------------------------------------------------------
package olar_pkg;

    // List capacity and the widths that follow from it.
    localparam int CAPACITY    = 16;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int COUNT_OUT_W = 5;

    // Input mode codes; any other code acts as a query.
    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_FULL      = 2'd3
    } t_status;

    // Input transaction payload.
    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] value;
    } t_in;

    // Output transaction payload.
    typedef struct packed {
        logic [1:0]             status;
        logic [COUNT_OUT_W-1:0] entry_count;
        logic signed [31:0]     head_value;
        logic signed [31:0]     tail_value;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    append;
        logic    remove;
        logic    load_out;
        t_status status;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic empty;
        logic found;
    } t_dp_stat;

endpackage

// ===== sv/ordered_list_append_remove.sv =====
// ----------------------------------------------------------------------------
// Ordered list with append and remove
// Usage: each input transaction (i_valid/o_ready) carries a mode and a signed
// 32-bit value: append at the tail, remove the first equal entry, or query.
// Each input transaction yields exactly one output transaction
// (o_valid/i_ready) with status, entry count, and the head and tail values
// after the operation (zero when the list is empty).
// An accepted input is captured while idle, then executed and its result
// loaded into the output register once that register is free, which raises
// o_valid. One transaction is in execution at a time; no new one is taken
// until the last has loaded its result. All entries are compared in
// parallel by the cell row.
// The output register lets the next input be accepted while a result waits;
// that transaction then holds in execution until the result is taken.
// Reset empties the list, idles the controller and clears o_valid; entry
// contents are left as they are and are never read until written again.
// ----------------------------------------------------------------------------
module ordered_list_append_remove (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  olar_pkg::t_in  i_in,
    output logic           o_valid,
    input  logic           i_ready,
    output olar_pkg::t_out o_out
);
    import olar_pkg::*;

    t_cmd     cmd;
    t_dp_stat stat;

    // Transaction sequencing.
    olar_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_mode  (i_in.mode),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Entry storage and result formation.
    olar_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_out   (o_out)
    );

endmodule

// ===== sv/olar_ctrl.sv =====
// ----------------------------------------------------------------------------
// Ordered list controller
// Sequences one transaction at a time: capture, then execute and load the
// output register once that register is free.
// ----------------------------------------------------------------------------
module olar_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_mode,
    output logic                o_valid,
    input  logic                i_ready,
    input  olar_pkg::t_dp_stat  i_stat,
    output olar_pkg::t_cmd      o_cmd
);
    import olar_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_mode, n_mode;
    logic       r_out_valid, n_out_valid;
    logic       out_free;
    logic       in_take;

    assign o_ready  = (r_state == ST_IDLE);
    assign o_valid  = r_out_valid;
    assign in_take  = i_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || i_ready;

    // Next state, commands and status decision.
    always_comb begin
        n_state        = r_state;
        n_mode         = r_mode;
        n_out_valid    = r_out_valid && !i_ready;
        o_cmd          = '0;
        o_cmd.status   = STATUS_OK;
        o_cmd.capture  = in_take;
        case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_mode  = i_mode;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    case (r_mode)
                        MODE_APPEND: begin
                            o_cmd.append = !i_stat.full;
                            o_cmd.status = i_stat.full ? STATUS_FULL : STATUS_OK;
                        end
                        MODE_REMOVE: begin
                            o_cmd.remove = i_stat.found;
                            if (i_stat.empty) begin
                                o_cmd.status = STATUS_EMPTY;
                            end else if (i_stat.found) begin
                                o_cmd.status = STATUS_OK;
                            end else begin
                                o_cmd.status = STATUS_NOT_FOUND;
                            end
                        end
                        default: begin
                            o_cmd.status = i_stat.empty ? STATUS_EMPTY : STATUS_OK;
                        end
                    endcase
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and registered handshake outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mode      <= MODE_QUERY;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== sv/olar_datapath.sv =====
// ----------------------------------------------------------------------------
// Ordered list datapath
// A row of entry cells that compare against the search value in parallel,
// shift down behind the first match on remove, and take a new tail on append.
// ----------------------------------------------------------------------------
module olar_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  olar_pkg::t_in       i_in,
    input  olar_pkg::t_cmd      i_cmd,
    output olar_pkg::t_dp_stat  o_stat,
    output olar_pkg::t_out      o_out
);
    import olar_pkg::*;

    logic signed [31:0] r_entries [CAPACITY];
    logic signed [31:0] n_entries [CAPACITY];
    logic [CNT_W-1:0]   r_count, n_count;
    logic signed [31:0] r_value;
    t_out               r_out;
    logic [CAPACITY-1:0] match;
    logic [CAPACITY-1:0] shift;
    logic [IDX_W-1:0]   tail_idx;
    logic [31:0]        cnt_ext;

    // Parallel compare of every held entry; shift marks the first hit onward.
    always_comb begin
        logic seen;
        seen = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            match[i] = (CNT_W'(i) < r_count) && (r_entries[i] == r_value);
            seen     = seen | match[i];
            shift[i] = seen;
        end
    end

    // Next contents of the entry row and the count.
    always_comb begin
        n_entries = r_entries;
        n_count   = r_count;
        if (i_cmd.append) begin
            n_entries[r_count[IDX_W-1:0]] = r_value;
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.remove) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                if (shift[i]) begin
                    n_entries[i] = r_entries[i+1];
                end
            end
            n_count = r_count - CNT_W'(1);
        end
    end

    assign tail_idx = IDX_W'(n_count - CNT_W'(1));
    assign cnt_ext  = 32'(n_count);

    // Status back to the controller.
    assign o_stat.full  = (r_count == CNT_W'(CAPACITY));
    assign o_stat.empty = (r_count == '0);
    assign o_stat.found = |match;

    // Entry cells, search value and output register carry no reset.
    always_ff @(posedge i_clk) begin
        r_entries <= n_entries;
        if (i_cmd.capture) begin
            r_value <= i_in.value;
        end
        if (i_cmd.load_out) begin
            r_out.status      <= i_cmd.status;
            r_out.entry_count <= cnt_ext[COUNT_OUT_W-1:0];
            if (n_count == '0) begin
                r_out.head_value <= '0;
                r_out.tail_value <= '0;
            end else begin
                r_out.head_value <= n_entries[0];
                r_out.tail_value <= n_entries[tail_idx];
            end
        end
    end

    // Entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_out = r_out;

endmodule

// ===== sim/ordered_list_append_remove_tb.sv =====
// ----------------------------------------------------------------------------
// Ordered list append/remove testbench
// Drives a short table of directed transactions and then a few hundred
// random ones, shaped as fill and drain phases so that the list reaches
// both empty and full. Each result is checked field by field against its
// directed row's expectation or else a shadow copy of the list. The sender
// works in bursts and the receiver stalls on a segmented random pattern.
// ----------------------------------------------------------------------------
module ordered_list_append_remove_tb;

    import olar_pkg::*;

    // Unused mode code, which the block treats as a query.
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 550;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

    // One row of the directed table.
    typedef struct {
        t_in  item;
        bit   has_exp;
        t_out exp_r;
    } t_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_in  i_in    = '0;
    logic o_ready;
    logic o_valid;
    t_out o_out;

    // Typed expectation that travels with the transaction being offered.
    bit   row_has_exp = 1'b0;
    t_out row_exp     = '0;

    // Shadow copy of the list and the queue of expected results.
    logic signed [31:0] shadow_vals [CAPACITY];
    int                 shadow_len = 0;
    t_out               expected_results [$];

    int   mismatches = 0;
    int   cycles     = 0;
    t_row dir_rows [$];

    ordered_list_append_remove u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_out   (o_out)
    );

    // Clock generation.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Apply one operation to the shadow list and return the result it gives.
    function automatic t_out apply_list_op(input t_in item);
        t_out r;
        int   hit;
        hit = -1;
        r = '0;
        case (item.mode)
            MODE_APPEND: begin
                if (shadow_len >= CAPACITY) begin
                    r.status = STATUS_FULL;
                end else begin
                    shadow_vals[shadow_len] = item.value;
                    shadow_len++;
                    r.status = STATUS_OK;
                end
            end
            MODE_REMOVE: begin
                if (shadow_len == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    for (int i = 0; i < shadow_len; i++) begin
                        if (hit < 0 && shadow_vals[i] == item.value) hit = i;
                    end
                    if (hit < 0) begin
                        r.status = STATUS_NOT_FOUND;
                    end else begin
                        // Close up the gap behind the removed entry.
                        for (int i = hit; i + 1 < shadow_len; i++) begin
                            shadow_vals[i] = shadow_vals[i + 1];
                        end
                        shadow_len--;
                        r.status = STATUS_OK;
                    end
                end
            end
            default: begin
                r.status = (shadow_len == 0) ? STATUS_EMPTY : STATUS_OK;
            end
        endcase
        r.entry_count = shadow_len[COUNT_OUT_W-1:0];
        if (shadow_len != 0) begin
            r.head_value = shadow_vals[0];
            r.tail_value = shadow_vals[shadow_len - 1];
        end
        return r;
    endfunction

    // Print one mismatch line and count it.
    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("MISMATCH at cycle %0d: %s got %0h expected %0h",
                 cycles, what, got, want);
        mismatches++;
    endtask

    // Offer one transaction and return at the edge where it is accepted.
    task automatic send_item(input t_in item, input bit has_exp, input t_out exp_r);
        i_valid     <= 1'b1;
        i_in        <= item;
        row_has_exp <= has_exp;
        row_exp     <= exp_r;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic add_row(input logic [1:0] mode, input logic signed [31:0] value,
                           input bit has_exp, input t_status st, input int cnt,
                           input logic signed [31:0] head, input logic signed [31:0] tail);
        t_row r;
        r.item.mode         = mode;
        r.item.value        = value;
        r.has_exp           = has_exp;
        r.exp_r.status      = st;
        r.exp_r.entry_count = cnt[COUNT_OUT_W-1:0];
        r.exp_r.head_value  = head;
        r.exp_r.tail_value  = tail;
        dir_rows.push_back(r);
    endtask

    // Monitor: predict on each accepted input, check each accepted result.
    always @(posedge i_clk) begin : monitor_blk
        t_out predicted;
        t_out want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                predicted = apply_list_op(i_in);
                expected_results.push_back(row_has_exp ? row_exp : predicted);
            end
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    flag_mismatch("result with no expectation, status",
                                  32'(o_out.status), '0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_out.status !== want.status)
                        flag_mismatch("status", 32'(o_out.status), 32'(want.status));
                    if (o_out.entry_count !== want.entry_count)
                        flag_mismatch("entry_count", 32'(o_out.entry_count),
                                      32'(want.entry_count));
                    if (o_out.head_value !== want.head_value)
                        flag_mismatch("head_value", o_out.head_value, want.head_value);
                    if (o_out.tail_value !== want.tail_value)
                        flag_mismatch("tail_value", o_out.tail_value, want.tail_value);
                end
            end
        end
    end

    // Receiver: stall probability changes from one segment to the next.
    always @(posedge i_clk) begin : receiver_blk
        int seg_left;
        int stall_pct;
        if (!i_rst_n) begin
            i_ready   <= 1'b0;
            seg_left  = 0;
            stall_pct = 0;
        end else begin
            if (seg_left == 0) begin
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    2:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
                seg_left = $urandom_range(20, 80);
            end
            seg_left--;
            i_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Cycle counter with a run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus.
    initial begin : stimulus_blk
        t_in  item;
        t_out no_exp;
        int   sent;
        int   burst;
        int   gap;
        int   pick;
        bit   filling;
        bit   paused;

        no_exp  = '0;
        sent    = 0;
        filling = 1'b1;
        paused  = 1'b0;

        // Directed table: empty-list cases, extremes, every mode, full list.
        add_row(MODE_QUERY,  32'sd0, 1, STATUS_EMPTY,     0, 32'sd0,  32'sd0);
        add_row(MODE_REMOVE, 32'sd5, 1, STATUS_EMPTY,     0, 32'sd0,  32'sd0);
        add_row(MODE_APPEND, VAL_MIN, 1, STATUS_OK,       1, VAL_MIN, VAL_MIN);
        add_row(MODE_APPEND, VAL_MAX, 1, STATUS_OK,       2, VAL_MIN, VAL_MAX);
        add_row(MODE_REMOVE, 32'sd0, 1, STATUS_NOT_FOUND, 2, VAL_MIN, VAL_MAX);
        add_row(MODE_QUERY,  32'sd0, 1, STATUS_OK,        2, VAL_MIN, VAL_MAX);
        add_row(MODE_UNUSED, -32'sd1, 1, STATUS_OK,       2, VAL_MIN, VAL_MAX);
        add_row(MODE_REMOVE, VAL_MIN, 1, STATUS_OK,       1, VAL_MAX, VAL_MAX);
        for (int k = 0; k < CAPACITY - 1; k++) begin
            add_row(MODE_APPEND, (k % 5) - 2, 0, STATUS_OK, 0, 32'sd0, 32'sd0);
        end
        add_row(MODE_APPEND, -32'sd1, 1, STATUS_FULL, CAPACITY, VAL_MAX, 32'sd2);
        add_row(MODE_REMOVE, 32'sd0, 0, STATUS_OK, 0, 32'sd0, 32'sd0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            send_item(dir_rows[r].item, dir_rows[r].has_exp, dir_rows[r].exp_r);
        end

        // Random part: fill and drain phases in bursts with random gaps.
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst; b++) begin
                // Phase may change once the list sits at full or empty, and rarely at random.
                if (shadow_len >= CAPACITY && $urandom_range(0, 2) == 0) filling = 1'b0;
                if (shadow_len == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
                if ($urandom_range(0, 99) == 0) filling = ~filling;

                pick = $urandom_range(0, 99);
                if (pick < 4)
                    item.mode = MODE_UNUSED;
                else if (pick < 12)
                    item.mode = MODE_QUERY;
                else if (pick < 76)
                    item.mode = filling ? MODE_APPEND : MODE_REMOVE;
                else
                    item.mode = filling ? MODE_REMOVE : MODE_APPEND;

                // Values mostly from a small pool so removes find matches.
                pick = $urandom_range(0, 99);
                if (item.mode == MODE_REMOVE && shadow_len > 0 && pick < 60)
                    item.value = shadow_vals[$urandom_range(0, shadow_len - 1)];
                else if (pick < 75)
                    item.value = $signed($urandom_range(0, 15)) - 32'sd8;
                else if (pick < 85)
                    item.value = ($urandom_range(0, 1) == 0) ? VAL_MIN : VAL_MAX;
                else
                    item.value = $urandom;

                send_item(item, 1'b0, no_exp);
                sent++;
                if (sent >= RANDOM_ITEMS) break;
            end

            if (!paused && sent >= RANDOM_ITEMS / 2) begin
                // Hold off until every outstanding result has come back.
                paused = 1'b1;
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (expected_results.size() != 0) @(posedge i_clk);
            end else if ($urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 6);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end

        // One edge first so that the last accepted transaction is queued.
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
